>>> rtl/cmwc_pkg.sv
// shared types, constants and tables of the contour molding width classifier
package cmwc_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned TurnW  = 20;
  localparam int unsigned AreaW  = 64;
  localparam int unsigned RadW   = 23;
  localparam int unsigned ScaleW = 17;
  localparam int unsigned WidthW = 23;

  localparam logic [TurnW-1:0] TurnMax     = 20'hFFFFF;
  localparam logic [29:0]      InvTwoPiQ32 = 30'd683565276;
  localparam logic [17:0]      PiQ16       = 18'd205887;
  localparam logic [16:0]      HalfPiQ16   = 17'd102944;
  localparam logic [15:0]      PiTurn      = 16'd25736;
  localparam logic [RadW-1:0]  RadMax      = 23'h7FFFFF;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

  // position of a vertex within its contour
  typedef enum logic [1:0] {
    CLS_FIRST,
    CLS_SECOND,
    CLS_MORE
  } vclass_e;

  typedef struct packed {
    vclass_e cls;
    logic    last;
    vertex_t v;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  typedef enum logic [2:0] {
    OP_AREA1,
    OP_TURN1,
    OP_AREA2,
    OP_TURN2,
    OP_TURN3,
    OP_SHIFT,
    OP_FINAL
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_POST,
    S_CORD,
    S_TURN,
    S_ADD,
    S_QMUL0,
    S_QMUL1,
    S_QSUM,
    S_SQRT,
    S_DECIDE,
    S_DIV,
    S_EMIT
  } state_e;

  // arctangent of 2^-i in Q.16
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] a;
    case (i)
      5'd0:    a = 17'd51472;
      5'd1:    a = 17'd30386;
      5'd2:    a = 17'd16055;
      5'd3:    a = 17'd8150;
      5'd4:    a = 17'd4091;
      5'd5:    a = 17'd2047;
      5'd6:    a = 17'd1024;
      5'd7:    a = 17'd512;
      5'd8:    a = 17'd256;
      5'd9:    a = 17'd128;
      5'd10:   a = 17'd64;
      5'd11:   a = 17'd32;
      5'd12:   a = 17'd16;
      5'd13:   a = 17'd8;
      5'd14:   a = 17'd4;
      5'd15:   a = 17'd2;
      5'd16:   a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/cmwc_front.sv
// front end: accepts vertices, tags their place in the contour and queues them
module cmwc_front #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cmwc_pkg::vertex_t      in_vertex_i,
  input  logic                   in_last_i,
  output cmwc_pkg::job_req_t     req_o,
  input  logic                   q_full_i
);
  import cmwc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_VERTICES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fire;
  vclass_e         cls;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    if (cnt_q == '0) begin
      cls = CLS_FIRST;
    end else if (cnt_q == CntW'(1)) begin
      cls = CLS_SECOND;
    end else begin
      cls = CLS_MORE;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (in_last_i) begin
        cnt_d = '0;
      end else if (cnt_q < MaxCnt) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign req_o.valid    = fire;
  assign req_o.job.cls  = cls;
  assign req_o.job.last = in_last_i;
  assign req_o.job.v    = in_vertex_i;

endmodule

>>> rtl/cmwc_fifo.sv
// short request queue between the front end and the back end
module cmwc_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

>>> rtl/cmwc_back.sv
// back end: area, cordic turn angles, radius and width scale per contour
module cmwc_back #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [22:0]         cfg_wdata_i,
  input  cmwc_pkg::job_t      job_i,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic signed [63:0]  double_area_o,
  output logic [22:0]         char_radius_o,
  output logic [19:0]         concave_turn_o,
  output logic                skip_molding_o,
  output logic [16:0]         width_scale_o
);
  import cmwc_pkg::*;

  localparam int unsigned IterW = $clog2(CORDIC_ITERATIONS);
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS - 1);

  state_e state_q, state_d;
  op_e    op_q, first_op, next_op;
  logic   emit;

  vertex_t p_q, f0_q, f1_q, pv0_q, pv1_q, prev_sel;
  logic    last_q;
  vclass_e cls_q;
  logic [WidthW-1:0] w_q;

  logic signed [24:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [24:0] ux_n, uy_n, vx_n, vy_n;
  logic signed [24:0] ma, mb;
  logic signed [49:0] mprod, prod_q;
  logic [2:0]         mcnt_q;
  logic signed [51:0] cr_q, dt_q;

  logic signed [52:0] cx_q, cy_q, xs, ys, dte, cre;
  logic signed [19:0] cz_q, atan_v;
  logic [IterW-1:0]   iter_q;
  logic signed [15:0] turn_q, turn_n, turn_neg;
  logic [16:0]        zc;
  logic [17:0]        th, thr_sum;
  logic [14:0]        tmag;

  logic signed [63:0] area_q;
  logic signed [64:0] area_sum;
  logic signed [63:0] area_sat;
  logic [TurnW-1:0]   neg_q, pos_q;
  logic [TurnW:0]     pos_sum, neg_sum;

  logic [63:0] mag;
  logic [61:0] qh_q, ql_q;
  logic [63:0] sv_q, sr_q, sbit_q, trial;
  logic [31:0] r;

  logic [TurnW-1:0] conc;
  logic [24:0]      w4, lim;
  logic [27:0]      w25;
  logic [26:0]      w10;
  logic [22:0]      conc5;
  logic             skip, zero_w, big_r, small_r, div_needed;
  logic [51:0]      rem_q;
  logic [43:0]      dsh_q;
  logic [16:0]      quo_q, quo_n;
  logic [4:0]       dcnt_q;
  logic             ge;

  logic [16:0] scale_q;
  logic [TurnW-1:0] conc_q;
  logic        skip_q;
  logic [22:0] rad_q;
  logic        out_valid_q;
  logic signed [63:0] out_area_q;
  logic [22:0] out_rad_q;
  logic [19:0] out_conc_q;
  logic        out_skip_q;
  logic [16:0] out_scale_q;

  function automatic logic signed [24:0] sx(input logic signed [23:0] a);
    return {a[23], a};
  endfunction

  // sequence of operations for one vertex
  always_comb begin
    if (job_i.cls != CLS_FIRST) begin
      first_op = OP_AREA1;
    end else if (job_i.last) begin
      first_op = OP_AREA2;
    end else begin
      first_op = OP_SHIFT;
    end
    case (op_q)
      OP_AREA1: begin
        if (cls_q == CLS_MORE) begin
          next_op = OP_TURN1;
        end else begin
          next_op = last_q ? OP_AREA2 : OP_SHIFT;
        end
      end
      OP_TURN1: next_op = last_q ? OP_AREA2 : OP_SHIFT;
      OP_AREA2: next_op = OP_TURN2;
      OP_TURN2: next_op = OP_TURN3;
      default:  next_op = OP_FINAL;
    endcase
  end

  // edge vectors for the next operation
  always_comb begin
    prev_sel = (cls_q == CLS_FIRST) ? p_q : pv1_q;
    case (op_q)
      OP_AREA1: begin
        ux_n = sx(pv1_q.x);  uy_n = sx(pv1_q.y);
        vx_n = sx(p_q.x);    vy_n = sx(p_q.y);
      end
      OP_TURN1: begin
        ux_n = sx(pv1_q.x) - sx(pv0_q.x);  uy_n = sx(pv1_q.y) - sx(pv0_q.y);
        vx_n = sx(p_q.x) - sx(pv1_q.x);    vy_n = sx(p_q.y) - sx(pv1_q.y);
      end
      OP_AREA2: begin
        ux_n = sx(p_q.x);   uy_n = sx(p_q.y);
        vx_n = sx(f0_q.x);  vy_n = sx(f0_q.y);
      end
      OP_TURN2: begin
        ux_n = sx(p_q.x) - sx(prev_sel.x);  uy_n = sx(p_q.y) - sx(prev_sel.y);
        vx_n = sx(f0_q.x) - sx(p_q.x);      vy_n = sx(f0_q.y) - sx(p_q.y);
      end
      default: begin
        ux_n = sx(f0_q.x) - sx(p_q.x);   uy_n = sx(f0_q.y) - sx(p_q.y);
        vx_n = sx(f1_q.x) - sx(f0_q.x);  vy_n = sx(f1_q.y) - sx(f0_q.y);
      end
    endcase
  end

  // shared multiplier: cross terms first, then dot terms
  always_comb begin
    case (mcnt_q)
      3'd0:    begin ma = ux_q; mb = vy_q; end
      3'd1:    begin ma = vx_q; mb = uy_q; end
      3'd2:    begin ma = ux_q; mb = vx_q; end
      3'd3:    begin ma = uy_q; mb = vy_q; end
      default: begin ma = ux_q; mb = vy_q; end
    endcase
    mprod = ma * mb;
  end

  // cordic step and turn rounding
  always_comb begin
    xs     = cx_q >>> iter_q;
    ys     = cy_q >>> iter_q;
    atan_v = {3'b000, atan_q16(5'(iter_q))};
    dte    = {dt_q[51], dt_q};
    cre    = {cr_q[51], cr_q};
    if (cz_q < 0) begin
      zc = '0;
    end else if (cz_q > $signed({3'b000, HalfPiQ16})) begin
      zc = HalfPiQ16;
    end else begin
      zc = cz_q[16:0];
    end
    th       = dt_q[51] ? (PiQ16 - {1'b0, zc}) : {1'b0, zc};
    thr_sum  = th + 18'd4;
    turn_n   = cr_q[51] ? -$signed({1'b0, thr_sum[17:3]}) : $signed({1'b0, thr_sum[17:3]});
    turn_neg = -turn_q;
    tmag     = turn_q[15] ? turn_neg[14:0] : turn_q[14:0];
    pos_sum  = {1'b0, pos_q} + {6'b0, tmag};
    neg_sum  = {1'b0, neg_q} + {6'b0, tmag};
  end

  // saturating area update
  always_comb begin
    area_sum = {area_q[63], area_q} + {{13{cr_q[51]}}, cr_q};
    if (area_sum[64] != area_sum[63]) begin
      area_sat = area_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      area_sat = area_sum[63:0];
    end
  end

  // end of contour decision
  always_comb begin
    mag        = area_q[63] ? (64'd0 - area_q) : area_q;
    trial      = sr_q + sbit_q;
    r          = sr_q[31:0];
    conc       = area_q[63] ? pos_q : neg_q;
    w4         = {w_q, 2'b00};
    lim        = (w4 > 25'd6144) ? w4 : 25'd6144;
    conc5      = {1'b0, conc, 2'b00} + {3'b000, conc};
    skip       = ({1'b0, r} < {8'b0, lim}) || (conc5 > 23'd32768);
    zero_w     = (w_q == '0);
    w25        = {1'b0, w_q, 4'b0000} + {2'b00, w_q, 3'b000} + {5'b0, w_q};
    w10        = {1'b0, w_q, 3'b000} + {3'b000, w_q, 1'b0};
    big_r      = ({r, 3'b000} >= {7'b0, w25});
    small_r    = (r < 32'd240);
    div_needed = !(skip || zero_w) && !big_r && !(small_r && (w10 <= 27'd768));
    ge         = ({8'b0, dsh_q} <= rem_q);
    quo_n      = {quo_q[15:0], ge};
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = S_SETUP;
        end
      end
      S_SETUP: begin
        case (op_q)
          OP_SHIFT: state_d = S_IDLE;
          OP_FINAL: state_d = S_QMUL0;
          default:  state_d = S_MUL;
        endcase
      end
      S_MUL: begin
        if (mcnt_q == 3'd4) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (op_q == OP_AREA1 || op_q == OP_AREA2) begin
          state_d = S_SETUP;
        end else if (cr_q == '0) begin
          state_d = S_ADD;
        end else begin
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (iter_q == IterLast) begin
          state_d = S_TURN;
        end
      end
      S_TURN:  state_d = S_ADD;
      S_ADD:   state_d = S_SETUP;
      S_QMUL0: state_d = S_QMUL1;
      S_QMUL1: state_d = S_QSUM;
      S_QSUM:  state_d = S_SQRT;
      S_SQRT: begin
        if (sbit_q[0]) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: state_d = div_needed ? S_DIV : S_EMIT;
      S_DIV: begin
        if (dcnt_q == 5'd16) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || res_ready_i) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // contour state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      f0_q        <= '0;
      f1_q        <= '0;
      pv0_q       <= '0;
      pv1_q       <= '0;
      area_q      <= '0;
      neg_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        w_q <= cfg_wdata_i;
      end
      if (job_pop_o) begin
        if (job_i.cls == CLS_FIRST) begin
          f0_q <= job_i.v;
          if (job_i.last) begin
            f1_q <= job_i.v;
          end
        end
        if (job_i.cls == CLS_SECOND) begin
          f1_q <= job_i.v;
        end
      end
      if (state_q == S_SETUP && op_q == OP_SHIFT) begin
        pv0_q <= pv1_q;
        pv1_q <= p_q;
      end
      if (state_q == S_POST && (op_q == OP_AREA1 || op_q == OP_AREA2)) begin
        area_q <= area_sat;
      end
      if (state_q == S_ADD) begin
        if (!turn_q[15] && turn_q != '0) begin
          pos_q <= pos_sum[TurnW] ? TurnMax : pos_sum[TurnW-1:0];
        end else if (turn_q[15]) begin
          neg_q <= neg_sum[TurnW] ? TurnMax : neg_sum[TurnW-1:0];
        end
      end
      if (emit) begin
        f0_q        <= '0;
        f1_q        <= '0;
        pv0_q       <= '0;
        pv1_q       <= '0;
        area_q      <= '0;
        neg_q       <= '0;
        pos_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (job_pop_o) begin
          p_q    <= job_i.v;
          last_q <= job_i.last;
          cls_q  <= job_i.cls;
          op_q   <= first_op;
        end
      end
      S_SETUP: begin
        ux_q   <= ux_n;
        uy_q   <= uy_n;
        vx_q   <= vx_n;
        vy_q   <= vy_n;
        mcnt_q <= '0;
      end
      S_MUL: begin
        prod_q <= mprod;
        mcnt_q <= mcnt_q + 3'd1;
        case (mcnt_q)
          3'd1:    cr_q <= {{2{prod_q[49]}}, prod_q};
          3'd2:    cr_q <= cr_q - {{2{prod_q[49]}}, prod_q};
          3'd3:    dt_q <= {{2{prod_q[49]}}, prod_q};
          3'd4:    dt_q <= dt_q + {{2{prod_q[49]}}, prod_q};
          default: cr_q <= cr_q;
        endcase
      end
      S_POST: begin
        if (op_q == OP_AREA1 || op_q == OP_AREA2) begin
          op_q <= next_op;
        end
        turn_q <= dt_q[51] ? PiTurn : 16'd0;
        cx_q   <= dte[52] ? -dte : dte;
        cy_q   <= cre[52] ? -cre : cre;
        cz_q   <= '0;
        iter_q <= '0;
      end
      S_CORD: begin
        iter_q <= iter_q + IterW'(1);
        if (!cy_q[52]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_v;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_v;
        end
      end
      S_TURN: turn_q <= turn_n;
      S_ADD:  op_q <= next_op;
      S_QMUL0: qh_q <= mag[63:32] * InvTwoPiQ32;
      S_QMUL1: ql_q <= mag[31:0] * InvTwoPiQ32;
      S_QSUM: begin
        sv_q   <= {2'b00, qh_q} + {34'b0, ql_q[61:32]};
        sr_q   <= '0;
        sbit_q <= {2'b01, 62'b0};
      end
      S_SQRT: begin
        if (sv_q >= trial) begin
          sv_q <= sv_q - trial;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      S_DECIDE: begin
        conc_q  <= conc;
        skip_q  <= skip;
        rad_q   <= (r > {9'b0, RadMax}) ? RadMax : r[22:0];
        scale_q <= (skip || zero_w) ? 17'd0 : 17'h10000;
        quo_q   <= '0;
        dcnt_q  <= '0;
        if (small_r) begin
          rem_q <= 52'd50331648;
          dsh_q <= {w10, 17'b0} >> 1;
        end else begin
          rem_q <= {1'b0, r, 19'b0};
          dsh_q <= {w25, 16'b0};
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_q <= rem_q - {8'b0, dsh_q};
        end
        dsh_q  <= dsh_q >> 1;
        quo_q  <= quo_n;
        dcnt_q <= dcnt_q + 5'd1;
        if (dcnt_q == 5'd16) begin
          scale_q <= quo_n;
        end
      end
      S_EMIT: begin
        if (emit) begin
          out_area_q  <= area_q;
          out_rad_q   <= rad_q;
          out_conc_q  <= conc_q;
          out_skip_q  <= skip_q;
          out_scale_q <= scale_q;
        end
      end
      default: op_q <= op_q;
    endcase
  end

  assign res_valid_o    = out_valid_q;
  assign double_area_o  = out_area_q;
  assign char_radius_o  = out_rad_q;
  assign concave_turn_o = out_conc_q;
  assign skip_molding_o = out_skip_q;
  assign width_scale_o  = out_scale_q;

endmodule

>>> rtl/contour_molding_width_classifier_unit.sv
// top level of the contour molding width classifier
// One closed contour streams in as vertices, one request each, the last one
// flagged by tlast; one result leaves per contour. The front end takes a vertex
// every cycle until its queue of QUEUE_DEPTH entries fills. The back end runs one
// shared 25x25 multiplier and one iterative CORDIC unit; it takes one vertex at a
// time, through the four multiply steps and the CORDIC iterations of its turn
// angle. The closing vertex adds the closing area term and two wrap-around turns,
// then a 32-step square root and up to a 17-step divide. The finished result sits
// in an output register, so the back end moves on to the next contour while it
// waits to be taken.
module contour_molding_width_classifier_unit #(
  parameter int unsigned MAX_VERTICES      = 1024,
  parameter int unsigned CORDIC_ITERATIONS = 16,
  parameter int unsigned QUEUE_DEPTH       = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [22:0]   cfg_wdata_i,    // profile_width
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // vertex_x, vertex_y
  input  logic          s_axis_tlast,   // last_vertex
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // double_area, char_radius, concave_turn,
                                        // width_scale, zero fill
  output logic          m_axis_tuser    // skip_molding
);
  import cmwc_pkg::*;

  job_req_t req;
  job_t     q_job;
  logic     q_full, q_valid, q_pop;
  vertex_t  in_v;
  logic signed [63:0] double_area;
  logic [22:0] char_radius;
  logic [19:0] concave_turn;
  logic [16:0] width_scale;

  assign in_v.x = s_axis_tdata[23:0];
  assign in_v.y = s_axis_tdata[47:24];

  cmwc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_vertex_i (in_v),
    .in_last_i   (s_axis_tlast),
    .req_o       (req),
    .q_full_i    (q_full)
  );

  cmwc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (JobW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req.valid),
    .wdata_i (req.job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_job),
    .valid_o (q_valid)
  );

  cmwc_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .job_i          (q_job),
    .job_valid_i    (q_valid),
    .job_pop_o      (q_pop),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .double_area_o  (double_area),
    .char_radius_o  (char_radius),
    .concave_turn_o (concave_turn),
    .skip_molding_o (m_axis_tuser),
    .width_scale_o  (width_scale)
  );

  assign m_axis_tdata = {4'b0000, width_scale, concave_turn, char_radius, double_area};

endmodule

>>> test/contour_molding_width_classifier_checker.sv
// checker for the contour molding width classifier: predicts contour results and compares
module contour_molding_width_classifier_checker #(
  parameter int unsigned MAX_VERTICES      = 1024,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [22:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);
  import cmwc_pkg::*;

  typedef struct packed {
    logic signed [63:0] area;
    logic [22:0]        radius;
    logic [19:0]        concave;
    logic               skip;
    logic [16:0]        scale;
  } contour_res_t;

  contour_res_t    expected_q[$];
  logic [22:0]     width_reg;
  longint          first_x[2], first_y[2], prev_x[2], prev_y[2];
  longint          area_acc;
  int unsigned     neg_sum, pos_sum, vcount;

  assign pending_o = expected_q.size();

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) return 64'sh7FFFFFFFFFFFFFFF;
    if (b < 0 && s > a) return 64'sh8000000000000000;
    return s;
  endfunction

  function automatic int unsigned atan_tab(int i);
    int unsigned t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                           128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? t[i] : 0;
  endfunction

  function automatic int turn_angle(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
    longint e1x, e1y, e2x, e2y, cr, dt, x, y, z, th, xs, ys;
    e1x = bx - ax; e1y = by - ay; e2x = cx - bx; e2y = cy - by;
    cr = e1x * e2y - e1y * e2x;
    dt = e1x * e2x + e1y * e2y;
    z = 0;
    if (cr == 0) return (dt < 0) ? int'(PiTurn) : 0;
    x = dt < 0 ? -dt : dt;
    y = cr < 0 ? -cr : cr;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      xs = asr(x, i); ys = asr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_tab(i));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(atan_tab(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HalfPiQ16)) z = longint'(HalfPiQ16);
    th = (dt < 0) ? longint'(PiQ16) - z : z;
    th = (th + 4) >>> 3;
    return int'(cr < 0 ? -th : th);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic add_turn(int t);
    if (t > 0) pos_sum = (pos_sum + t > TurnMax) ? TurnMax : pos_sum + t;
    else if (t < 0) neg_sum = (neg_sum - t > TurnMax) ? TurnMax : neg_sum - t;
  endtask

  task automatic clear_contour();
    first_x = '{0, 0}; first_y = '{0, 0}; prev_x = '{0, 0}; prev_y = '{0, 0};
    area_acc = 0; neg_sum = 0; pos_sum = 0; vcount = 0;
  endtask

  task automatic take_vertex(logic [47:0] d, logic lst);
    longint px, py, qx, qy;
    longint unsigned mag, q, r, w, lim, sc;
    int unsigned k, conc;
    logic sk;
    contour_res_t e;
    k = vcount;
    px = longint'($signed(d[23:0]));
    py = longint'($signed(d[47:24]));
    qx = (k == 0) ? px : prev_x[1];
    qy = (k == 0) ? py : prev_y[1];
    if (k < 2) begin
      first_x[k] = px; first_y[k] = py;
    end
    if (k >= 1) area_acc = sat_add(area_acc, qx * py - px * qy);
    if (k >= 2) add_turn(turn_angle(prev_x[0], prev_y[0], prev_x[1], prev_y[1], px, py));
    if (!lst) begin
      prev_x[0] = prev_x[1]; prev_y[0] = prev_y[1];
      prev_x[1] = px; prev_y[1] = py;
      if (vcount < MAX_VERTICES) vcount++;
      return;
    end
    if (k == 0) begin
      first_x[1] = px; first_y[1] = py;
    end
    area_acc = sat_add(area_acc, px * first_y[0] - first_x[0] * py);
    add_turn(turn_angle(qx, qy, px, py, first_x[0], first_y[0]));
    add_turn(turn_angle(px, py, first_x[0], first_y[0], first_x[1], first_y[1]));
    mag = area_acc < 0 ? 64'd0 - longint'(area_acc) : area_acc;
    q = (mag >> 32) * InvTwoPiQ32 + (((mag & 64'hFFFFFFFF) * InvTwoPiQ32) >> 32);
    r = int_sqrt(q);
    conc = (area_acc >= 0) ? neg_sum : pos_sum;
    w = width_reg;
    lim = 4 * w > 6144 ? 4 * w : 6144;
    sk = (r < lim) || (longint'(conc) * 5 > 32768);
    if (sk || w == 0) sc = 0;
    else if (8 * r >= 25 * w) sc = 65536;
    else if (32 * r < 7680) sc = (10 * w <= 768) ? 65536 : (768 * 65536) / (10 * w);
    else sc = (8 * r * 65536) / (25 * w);
    e.area = area_acc;
    e.radius = r > 8388607 ? 23'h7FFFFF : r[22:0];
    e.concave = conc[19:0];
    e.skip = sk;
    e.scale = sc[16:0];
    expected_q = {expected_q, e};
    clear_contour();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    contour_res_t got, exp_r;
    if (!rst_ni) begin
      width_reg <= '0;
      clear_contour();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) width_reg <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) take_vertex(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.area = m_axis_tdata[63:0];
        got.radius = m_axis_tdata[86:64];
        got.concave = m_axis_tdata[106:87];
        got.scale = m_axis_tdata[123:107];
        got.skip = m_axis_tuser;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r || m_axis_tdata[127:124] != 0) begin
            $display("%0t: mismatch exp area=%0d rad=%0d conc=%0d skip=%0b scale=%0d",
                     $time, exp_r.area, exp_r.radius, exp_r.concave, exp_r.skip,
                     exp_r.scale);
            $display("%0t:          got area=%0d rad=%0d conc=%0d skip=%0b scale=%0d",
                     $time, got.area, got.radius, got.concave, got.skip, got.scale);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/contour_molding_width_classifier_unit_tb.sv
// testbench top for the contour molding width classifier: stimulus and verdict
module contour_molding_width_classifier_unit_tb;

  logic         clk_i, rst_ni;
  logic         cfg_we_i;
  logic [22:0]  cfg_wdata_i;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [47:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [127:0] m_axis_tdata;
  int           fail_count, pending;
  bit           stall_burst;

  contour_molding_width_classifier_unit u_dut (.*);

  contour_molding_width_classifier_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls in runs, sometimes for a whole run, otherwise at random
  initial begin
    int run;
    m_axis_tready = 0;
    forever begin
      run = $urandom_range(1, 40);
      stall_burst = ($urandom_range(0, 3) == 0);
      repeat (run) begin
        @(negedge clk_i);
        m_axis_tready <= stall_burst ? 1'b0 : ($urandom_range(0, 4) != 0);
      end
    end
  end

  int gap_left, burst_left;

  task automatic send_vertex(logic signed [23:0] x, logic signed [23:0] y, logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap_left > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap_left) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {y, x};
    s_axis_tlast <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_then_config(logic [22:0] w);
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic signed [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8000)) - 4000);
      default: return 24'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // a regular polygon with random jitter, sometimes with a notch for a concave turn
  task automatic send_polygon(int n, int rad, bit cw, bit notch);
    real a;
    int  x, y, rr;
    for (int i = 0; i < n; i++) begin
      a = 6.283185307 * i / n;
      if (cw) a = -a;
      rr = (notch && i % 3 == 1) ? rad / 3 : rad;
      x = int'(rr * $cos(a)) + $urandom_range(0, 50);
      y = int'(rr * $sin(a)) + $urandom_range(0, 50);
      send_vertex(24'(x), 24'(y), i == n - 1);
    end
  endtask

  initial begin
    int n, sent, mode, kind;
    rst_ni = 0; cfg_we_i = 0; cfg_wdata_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    burst_left = 0; gap_left = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: width zero, extremes, degenerate contours
    send_vertex(24'sh7FFFFF, 24'sh800000, 1);                  // single vertex
    send_vertex(24'sh800000, 24'sh800000, 0);                  // two vertices
    send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 1);
    send_vertex(0, 0, 0); send_vertex(1000, 0, 0);             // straight reversal
    send_vertex(0, 0, 0); send_vertex(0, 0, 1);                // zero-length edge
    send_vertex(24'sh800000, 24'sh800000, 0);                  // full-range square
    send_vertex(24'sh7FFFFF, 24'sh800000, 0);
    send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_vertex(24'sh800000, 24'sh7FFFFF, 1);
    idle_then_config(23'd1536);
    send_polygon(8, 100000, 0, 0);
    send_polygon(9, 100000, 1, 1);
    send_polygon(4, 3000, 0, 0);
    idle_then_config(23'h7FFFFF);
    send_polygon(6, 8000000, 0, 0);
    idle_then_config(23'd1);
    send_polygon(5, 6000, 0, 0);
    send_polygon(5, 2000, 0, 0);
    idle_then_config(23'd20000);
    send_polygon(7, 600000, 0, 0);

    sent = 0;
    while (sent < 1000) begin
      if ($urandom_range(0, 7) == 0)
        idle_then_config($urandom_range(0, 3) == 0 ? 23'($urandom) :
                         23'($urandom_range(0, 40000)));
      kind = $urandom_range(0, 9);
      n = $urandom_range(1, 12);
      if (kind < 6) begin
        send_polygon(n + 2, $urandom_range(1000, 3000000), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        sent += n + 2;
      end else begin
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
          send_vertex(rnd_coord(mode), rnd_coord(mode), i == n - 1);
        sent += n;
      end
    end
    // sometimes one contour past the vertex count limit
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 1030; i++)
        send_vertex(24'($urandom_range(0, 4000)), 24'($urandom_range(0, 4000)), i == 1029);
    end

    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/cmwc_pkg.sv
rtl/cmwc_front.sv
rtl/cmwc_fifo.sv
rtl/cmwc_back.sv
rtl/contour_molding_width_classifier_unit.sv
test/contour_molding_width_classifier_checker.sv
test/contour_molding_width_classifier_unit_tb.sv
